// ----- src/random_cyclic_chain_builder_defines.svh -----
// Assertion macros for the chain builder checker
`ifndef RANDOM_CYCLIC_CHAIN_BUILDER_DEFINES_SVH
`define RANDOM_CYCLIC_CHAIN_BUILDER_DEFINES_SVH

// same-cycle implication
`define RCCB_AST_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RCCB_AST_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/rccb_pkg.sv -----
// Package for the random cyclic chain builder: constants, types, helper functions
package rccb_pkg;

	localparam int LINES      = 8192;
	localparam int LINE_BYTES = 64;
	localparam int IW         = $clog2(LINES);
	localparam int DW         = $clog2(LINES + 1);
	localparam int LINE_SHIFT   = $clog2(LINE_BYTES);
	localparam int STREAM_SHIFT = $clog2(LINES * LINE_BYTES);

	localparam int OP_W     = 1;
	localparam int STREAM_W = 3;
	localparam int LINE_W   = 13;
	localparam int ADDR_W   = 64;
	localparam int STATUS_W = 1;

	localparam int S_TDATA_W = ((STREAM_W + LINE_W + 7) / 8) * 8;
	localparam int M_RAW_W   = LINE_W + ADDR_W;
	localparam int M_TDATA_W = ((M_RAW_W + 7) / 8) * 8;

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 64;
	localparam logic REG_REGION_BASE = 1'b0;

	localparam int GEN_W = 64;
	localparam logic [GEN_W-1:0] SEED_CONST = 64'h9e3779b97f4a7c15;
	localparam int SH_A = 13;
	localparam int SH_B = 7;
	localparam int SH_C = 17;
	localparam int STREAM_POS = 32;

	localparam int RADIX_BITS = 4;
	localparam int DIV_CYCLES = GEN_W / RADIX_BITS;
	localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

	localparam logic [OP_W-1:0] OP_BUILD  = 1'b0;
	localparam logic [OP_W-1:0] OP_FOLLOW = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK        = 1'b0;
	localparam logic [STATUS_W-1:0] ST_NOT_BUILT = 1'b1;

	typedef enum logic [2:0] {
		IDX_HOLD,
		IDX_ZERO,
		IDX_TOP,
		IDX_INC,
		IDX_DEC
	} idx_op_t;

	typedef enum logic [1:0] {
		RES_BUILD,
		RES_FOLLOW,
		RES_NOTBUILT
	} res_sel_t;

	typedef struct packed {
		logic     accept_build;
		logic     accept_follow;
		logic     init_wr;
		logic     gen;
		logic     rd_j;
		logic     wr_j;
		logic     wr_i;
		logic     link_rd;
		logic     link_wr;
		logic     link_last;
		logic     load_out;
		res_sel_t res_sel;
		idx_op_t  idx_op;
	} rccb_cmd_t;

	typedef struct packed {
		logic idx_one;
		logic idx_last;
		logic div_done;
		logic built;
		logic out_free;
	} rccb_sts_t;

	function automatic logic [GEN_W-1:0] seed_of(input logic [STREAM_W-1:0] stream);
		logic [GEN_W-1:0] s;
		s = SEED_CONST ^ (GEN_W'(stream) << STREAM_POS) ^ GEN_W'(LINES * LINE_BYTES);
		return s;
	endfunction

	function automatic logic [GEN_W-1:0] xorshift(input logic [GEN_W-1:0] x_in);
		logic [GEN_W-1:0] x;
		x = x_in;
		x = x ^ (x << SH_A);
		x = x ^ (x >> SH_B);
		x = x ^ (x << SH_C);
		return x;
	endfunction

endpackage

// ----- src/rccb_mod.sv -----
// Iterative radix-16 remainder unit: 64-bit dividend modulo a narrow divisor
module rccb_mod import rccb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [GEN_W-1:0] dividend,
	input  logic [DW-1:0]    divisor,
	output logic             done,
	output logic [DW-1:0]    rem
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [GEN_W-1:0]     x_q;
	logic [DW-1:0]        d_q;
	logic [DW-1:0]        r_q;
	logic [DW-1:0]        r_nx;

	always_comb begin
		logic [DW:0] t;
		r_nx = r_q;
		for (int k = 0; k < RADIX_BITS; k++) begin
			t = {r_nx, x_q[GEN_W-1-k]};
			if (t >= {1'b0, d_q}) begin
				t = t - {1'b0, d_q};
			end
			r_nx = t[DW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(DIV_CYCLES - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= dividend;
			d_q <= divisor;
			r_q <= '0;
		end else if (busy_q) begin
			x_q <= x_q << RADIX_BITS;
			r_q <= r_nx;
		end
	end

	assign done = done_q;
	assign rem  = r_q;

endmodule

// ----- src/rccb_dp.sv -----
// Datapath: generator, order and successor memories, address adder, result register
module rccb_dp import rccb_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  rccb_cmd_t           cmd,
	output rccb_sts_t           sts,
	input  logic [STREAM_W-1:0] stream_id,
	input  logic [LINE_W-1:0]   line_index,
	input  logic                cfg_wr,
	input  logic [PDATA_W-1:0]  cfg_wdata,
	output logic [PDATA_W-1:0]  base,
	input  logic                out_ready,
	output logic                out_valid,
	output logic [LINE_W-1:0]   out_line,
	output logic [ADDR_W-1:0]   out_addr,
	output logic [STATUS_W-1:0] out_status
);

	logic [IW-1:0] order_mem [LINES];
	logic [IW-1:0] succ_mem  [LINES];

	logic [GEN_W-1:0]    gen_q;
	logic [GEN_W-1:0]    gen_nx;
	logic [STREAM_W-1:0] stream_q;
	logic                built_q;
	logic [ADDR_W-1:0]   base_q;
	logic [IW-1:0]       idx_q;
	logic [IW-1:0]       first_q;
	logic [IW-1:0]       prev_q;
	logic [IW-1:0]       oi_q;
	logic [IW-1:0]       oj_q;
	logic [IW-1:0]       succ_rd_q;
	logic                out_valid_q;
	logic [LINE_W-1:0]   out_line_q;
	logic [ADDR_W-1:0]   out_addr_q;
	logic [STATUS_W-1:0] out_status_q;

	logic            div_done;
	logic [DW-1:0]   rem;
	logic [IW-1:0]   j;
	logic            ord_we;
	logic [IW-1:0]   ord_waddr;
	logic [IW-1:0]   ord_wdata;
	logic            succ_we;
	logic [IW-1:0]   succ_wdata;
	logic [IW-1:0]   res_line;
	logic [ADDR_W-1:0] res_addr;

	assign gen_nx = xorshift(gen_q);
	assign j      = rem[IW-1:0];

	rccb_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.gen),
		.dividend (gen_nx),
		.divisor  (DW'(idx_q) + DW'(1)),
		.done     (div_done),
		.rem      (rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q    <= '0;
			stream_q <= '0;
			built_q  <= 1'b0;
			base_q   <= '0;
		end else begin
			if (cfg_wr) begin
				base_q <= cfg_wdata;
			end
			if (cmd.accept_build) begin
				gen_q    <= seed_of(stream_id);
				stream_q <= stream_id;
				built_q  <= 1'b1;
			end else if (cmd.gen) begin
				gen_q <= gen_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.idx_op)
			IDX_HOLD: idx_q <= idx_q;
			IDX_ZERO: idx_q <= '0;
			IDX_TOP:  idx_q <= IW'(LINES - 1);
			IDX_INC:  idx_q <= idx_q + IW'(1);
			IDX_DEC:  idx_q <= idx_q - IW'(1);
			default:  idx_q <= idx_q;
		endcase
	end

	always_comb begin
		ord_we    = cmd.init_wr || cmd.wr_j || cmd.wr_i;
		ord_waddr = idx_q;
		ord_wdata = idx_q;
		if (cmd.wr_j) begin
			ord_waddr = j;
			ord_wdata = oi_q;
		end else if (cmd.wr_i) begin
			ord_wdata = oj_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ord_we) begin
			order_mem[ord_waddr] <= ord_wdata;
		end
		if (cmd.gen || cmd.link_rd) begin
			oi_q <= order_mem[idx_q];
		end
		if (cmd.rd_j) begin
			oj_q <= order_mem[j];
		end
	end

	assign succ_we    = (cmd.link_wr && idx_q != '0) || cmd.link_last;
	assign succ_wdata = cmd.link_last ? first_q : oi_q;

	always_ff @(posedge clk) begin
		if (succ_we) begin
			succ_mem[prev_q] <= succ_wdata;
		end
		if (cmd.accept_follow) begin
			succ_rd_q <= succ_mem[line_index[IW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.link_wr) begin
			prev_q <= oi_q;
			if (idx_q == '0) begin
				first_q <= oi_q;
			end
		end
	end

	assign res_line = (cmd.res_sel == RES_BUILD) ? first_q : succ_rd_q;
	assign res_addr = base_q + (ADDR_W'(stream_q) << STREAM_SHIFT)
	                + (ADDR_W'(res_line) << LINE_SHIFT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			unique case (cmd.res_sel)
				RES_BUILD, RES_FOLLOW: begin
					out_line_q   <= LINE_W'(res_line);
					out_addr_q   <= res_addr;
					out_status_q <= ST_OK;
				end
				default: begin
					out_line_q   <= '0;
					out_addr_q   <= '0;
					out_status_q <= ST_NOT_BUILT;
				end
			endcase
		end
	end

	assign sts.idx_one  = (idx_q == IW'(1));
	assign sts.idx_last = (idx_q == IW'(LINES - 1));
	assign sts.div_done = div_done;
	assign sts.built    = built_q;
	assign sts.out_free = !out_valid_q || out_ready;

	assign base       = base_q;
	assign out_valid  = out_valid_q;
	assign out_line   = out_line_q;
	assign out_addr   = out_addr_q;
	assign out_status = out_status_q;

endmodule

// ----- src/rccb_ctrl.sv -----
// Controller: sequences build (init, shuffle, link) and follow lookups
module rccb_ctrl import rccb_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [OP_W-1:0] in_op,
	output logic            in_ready,
	input  rccb_sts_t       sts,
	output rccb_cmd_t       cmd
);

	typedef enum logic [10:0] {
		S_IDLE  = 11'b000_0000_0001,
		S_INIT  = 11'b000_0000_0010,
		S_GEN   = 11'b000_0000_0100,
		S_DIV   = 11'b000_0000_1000,
		S_RDJ   = 11'b000_0001_0000,
		S_SWJ   = 11'b000_0010_0000,
		S_SWI   = 11'b000_0100_0000,
		S_LRD   = 11'b000_1000_0000,
		S_LWR   = 11'b001_0000_0000,
		S_LLAST = 11'b010_0000_0000,
		S_RESP  = 11'b100_0000_0000
	} state_t;

	state_t   state_q, state_nx;
	res_sel_t kind_q, kind_nx;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_nx = state_q;
		kind_nx  = kind_q;
		cmd      = '0;
		cmd.res_sel = kind_q;
		cmd.idx_op  = IDX_HOLD;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (in_op == OP_BUILD) begin
						cmd.accept_build = 1'b1;
						cmd.idx_op       = IDX_ZERO;
						state_nx         = S_INIT;
					end else begin
						cmd.accept_follow = 1'b1;
						kind_nx  = sts.built ? RES_FOLLOW : RES_NOTBUILT;
						state_nx = S_RESP;
					end
				end
			end
			S_INIT: begin
				cmd.init_wr = 1'b1;
				if (sts.idx_last) begin
					cmd.idx_op = IDX_TOP;
					state_nx   = S_GEN;
				end else begin
					cmd.idx_op = IDX_INC;
				end
			end
			S_GEN: begin
				cmd.gen  = 1'b1;
				state_nx = S_DIV;
			end
			S_DIV: begin
				if (sts.div_done) begin
					state_nx = S_RDJ;
				end
			end
			S_RDJ: begin
				cmd.rd_j = 1'b1;
				state_nx = S_SWJ;
			end
			S_SWJ: begin
				cmd.wr_j = 1'b1;
				state_nx = S_SWI;
			end
			S_SWI: begin
				cmd.wr_i = 1'b1;
				if (sts.idx_one) begin
					cmd.idx_op = IDX_ZERO;
					state_nx   = S_LRD;
				end else begin
					cmd.idx_op = IDX_DEC;
					state_nx   = S_GEN;
				end
			end
			S_LRD: begin
				cmd.link_rd = 1'b1;
				state_nx    = S_LWR;
			end
			S_LWR: begin
				cmd.link_wr = 1'b1;
				if (sts.idx_last) begin
					state_nx = S_LLAST;
				end else begin
					cmd.idx_op = IDX_INC;
					state_nx   = S_LRD;
				end
			end
			S_LLAST: begin
				cmd.link_last = 1'b1;
				kind_nx       = RES_BUILD;
				state_nx      = S_RESP;
			end
			S_RESP: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q  <= RES_BUILD;
		end else begin
			state_q <= state_nx;
			kind_q  <= kind_nx;
		end
	end

endmodule

// ----- src/random_cyclic_chain_builder.sv -----
// Top level of the random cyclic chain builder
// Usage:
//   Input beats on s_*: s_tuser is the op (build or follow). A build beat
//   seeds a xorshift64 generator from the stream number, shuffles all lines
//   (Fisher-Yates) and links them into one cycle; its single result beat
//   carries the start line. A follow beat returns the successor of a line.
//   Every OK result carries the line's byte address in the current stream.
//   The user must write region_base over APB only while the block is idle;
//   the block does not enforce this.
// Timing:
//   Follow: the result is registered after accept; a new beat is taken
//   only after the previous result is loaded. Build: the shuffle dominates:
//   each of the LINES-1 swaps waits on the remainder unit, 4 quotient bits
//   a cycle over a 64-bit word, then reads and writes the order memory over
//   its single write port. s_tready is low for the whole build.
// Reset: no chain exists; a follow then answers with status not built.
//   Table memories are not cleared; a build writes every entry.
// Stall: the result sits in an output register until m_tready; one more
//   input beat may be accepted meanwhile and waits for that register.
module random_cyclic_chain_builder import rccb_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // stream_id[2:0], line_index[15:3]
	input  logic [OP_W-1:0]      s_tuser,   // op[0]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // next_line[12:0], line_address[76:13], zeros
	output logic [STATUS_W-1:0]  m_tuser,   // status[0]
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [PDATA_W-1:0]   pwdata,
	output logic [PDATA_W-1:0]   prdata,
	output logic                 pready
);

	rccb_cmd_t           cmd;
	rccb_sts_t           sts;
	logic                cfg_wr;
	logic [PDATA_W-1:0]  base;
	logic [LINE_W-1:0]   out_line;
	logic [ADDR_W-1:0]   out_addr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[3] == REG_REGION_BASE);
	assign prdata = (paddr[3] == REG_REGION_BASE) ? base : '0;

	rccb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_op    (s_tuser),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rccb_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.stream_id  (s_tdata[STREAM_W-1:0]),
		.line_index (s_tdata[STREAM_W+LINE_W-1:STREAM_W]),
		.cfg_wr     (cfg_wr),
		.cfg_wdata  (pwdata),
		.base       (base),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.out_line   (out_line),
		.out_addr   (out_addr),
		.out_status (m_tuser)
	);

	assign m_tdata = M_TDATA_W'({out_addr, out_line});

endmodule

// ----- src/rccb_checker.sv -----
// Port-level checker for the chain builder, bound to the top level
`include "random_cyclic_chain_builder_defines.svh"

module rccb_checker import rccb_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic [STATUS_W-1:0]  m_tuser
);

	`RCCB_AST_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result beat dropped while stalled")
	`RCCB_AST_NXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata), "result beat changed while stalled")
	`RCCB_AST_NOW(a_notbuilt_zero, m_tvalid && (m_tuser == ST_NOT_BUILT), m_tdata == '0, "not-built result carries data")
	`RCCB_AST_NXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "input taken while previous beat still in work")

endmodule

bind random_cyclic_chain_builder rccb_checker u_rccb_checker (.*);
